// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. All are sampled on the rising edge of aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_ON_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/sru_pkg.sv
package sru_pkg;

    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 24;

    // Control that travels alongside each beat through the cell chain.
    typedef struct packed {
        logic valid;
        logic invalid;
    } sru_ctl_t;

endpackage

// File: rtl/sru_cell.sv
module sru_cell
    import sru_pkg::*;
#(
    parameter int ROOT_BITS = 24,
    parameter int RAD_W     = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  sru_ctl_t             ctl_in,
    input  logic [RAD_W-1:0]     rad_in,
    input  logic [ROOT_BITS+1:0] rem_in,
    input  logic [ROOT_BITS-1:0] q_in,
    output sru_ctl_t             ctl_out,
    output logic [RAD_W-1:0]     rad_out,
    output logic [ROOT_BITS+1:0] rem_out,
    output logic [ROOT_BITS-1:0] q_out
);

    sru_ctl_t             ctl_reg;
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic [ROOT_BITS+1:0] rem_reg, rem_next;
    logic [ROOT_BITS-1:0] q_reg, q_next;

    logic [ROOT_BITS+1:0] rem_shift;
    logic [ROOT_BITS+1:0] trial;
    logic [ROOT_BITS+2:0] diff;
    logic                 fits;

    // One restoring step: bring down the next two radicand bits and try
    // the trial divisor 4q+1.
    always_comb begin
        rem_shift = {rem_in[ROOT_BITS-1:0], rad_in[RAD_W-1 -: 2]};
        trial     = {q_in, 2'b01};
        diff      = {1'b0, rem_shift} - {1'b0, trial};
        fits      = !diff[ROOT_BITS+2];
        rem_next  = fits ? diff[ROOT_BITS+1:0] : rem_shift;
        q_next    = {q_in[ROOT_BITS-2:0], fits};
        rad_next  = rad_in << 2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= rad_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rad_out = rad_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

// File: rtl/square_root_unit.sv
// Square root unit: floor(sqrt(x)) for a signed fixed-point radicand.
// Input channel s_*: one radicand beat in signed Q(31-FRAC_BITS).FRAC_BITS.
// Output channel m_*: one result beat per input beat, in input order; m_root
// is unsigned Q.FRAC_BITS, m_invalid flags a negative radicand (root then 0).
// The datapath is a chain of (31+FRAC_BITS+1)/2 identical cells, 24 at the
// default FRAC_BITS of 16. Each cell resolves one root bit with one add and
// compare of about 26 bits and registers its result.
// Each cell's register is a pipeline stage; a beat passes through the
// registers of all the cells in order before it reaches the output.
// Throughput: one beat per cycle while the output is not stalled; the last
// cell's register is the output register, so a new radicand enters while
// earlier ones are still in flight. Stall: while m_valid is high and m_ready
// is low the whole chain holds and s_ready drops; nothing is lost or repeated,
// and the chain moves on once the output beat is taken.
// Reset: aresetn (synchronous, active low) empties the chain; items in
// flight are dropped and m_valid is low on the first cycle after reset.
module square_root_unit
    import sru_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [RADICAND_W-1:0] s_radicand,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [ROOT_W-1:0]     m_root,
    output logic                         m_invalid
);

    localparam int VAL_W     = RADICAND_W - 1 + FRAC_BITS;
    localparam int ROOT_BITS = (VAL_W + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_BITS;

    sru_ctl_t             ctl [0:ROOT_BITS];
    logic [RAD_W-1:0]     rad [0:ROOT_BITS];
    logic [ROOT_BITS+1:0] rem [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] q   [0:ROOT_BITS];

    logic advance;
    logic negative;

    assign advance  = !ctl[ROOT_BITS].valid || m_ready;
    assign s_ready  = advance;
    assign negative = s_radicand[RADICAND_W-1];

    always_comb begin
        ctl[0].valid   = s_valid;
        ctl[0].invalid = negative;
        // A negative radicand runs through as zero, which yields a zero root.
        rad[0] = negative ? '0 : (RAD_W'(s_radicand[RADICAND_W-2:0]) << FRAC_BITS);
        rem[0] = '0;
        q[0]   = '0;
    end

    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
        sru_cell #(
            .ROOT_BITS(ROOT_BITS),
            .RAD_W    (RAD_W)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (advance),
            .ctl_in (ctl[i]),
            .rad_in (rad[i]),
            .rem_in (rem[i]),
            .q_in   (q[i]),
            .ctl_out(ctl[i+1]),
            .rad_out(rad[i+1]),
            .rem_out(rem[i+1]),
            .q_out  (q[i+1])
        );
    end

    assign m_valid   = ctl[ROOT_BITS].valid;
    assign m_invalid = ctl[ROOT_BITS].invalid;
    assign m_root    = ROOT_W'(q[ROOT_BITS]);

`include "assert_macros.svh"

    `ASSERT_ON_CLK(a_invalid_zero_root, m_valid && m_invalid |-> q[ROOT_BITS] == '0, "invalid beat with nonzero root")
    `ASSERT_ON_CLK(a_floor_root, m_valid |-> rem[ROOT_BITS] <= {1'b0, q[ROOT_BITS], 1'b0}, "final remainder exceeds 2*root")
    `ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid, "output valid right after reset")

endmodule

// File: tb/square_root_unit_tb.sv
`timescale 1ns / 100ps

module square_root_unit_tb;
    import sru_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int CHAIN_DEPTH   = (31 + FRAC_BITS + 1) / 2;
    localparam int RANDOM_ITEMS  = 550;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [RADICAND_W-1:0] radicand;
        int unsigned           gap;
        bit                    drain;
    } radicand_item_t;

    typedef struct {
        logic [RADICAND_W-1:0] radicand;
        logic [ROOT_W-1:0]     root;
        logic                  invalid;
    } root_beat_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [RADICAND_W-1:0] s_radicand = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic        [ROOT_W-1:0]     m_root;
    logic                         m_invalid;

    radicand_item_t pending_q[$];
    root_beat_t     root_expect_q[$];
    int unsigned    launch_wait = 0;
    int unsigned    hold_left = 0;
    int unsigned    results_seen = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    err_count = 0;

    square_root_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_radicand(s_radicand),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_root    (m_root),
        .m_invalid (m_invalid)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Floor of sqrt(radicand * 2^FRAC_BITS), resolved two bits of the operand at a time.
    function automatic root_beat_t predict_root(logic [RADICAND_W-1:0] radicand);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        root_beat_t  beat;
        beat.radicand = radicand;
        beat.invalid  = radicand[RADICAND_W-1];
        beat.root     = '0;
        if (!radicand[RADICAND_W-1]) begin
            rem   = {32'b0, radicand} << FRAC_BITS;
            res   = '0;
            probe = 64'h1 << 62;
            while (probe > rem)
                probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= res + probe) begin
                    rem = rem - (res + probe);
                    res = (res >> 1) + probe;
                end else begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
            beat.root = res[ROOT_W-1:0];
        end
        return beat;
    endfunction

    function automatic void queue_radicand(logic [RADICAND_W-1:0] value, int unsigned gap,
                                           bit drain);
        radicand_item_t item;
        item.radicand = value;
        item.gap      = gap;
        item.drain    = drain;
        pending_q.push_back(item);
    endfunction

    task automatic flag_mismatch(string what, logic [RADICAND_W-1:0] radicand,
                                 longint unsigned want, longint unsigned got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch for radicand %h: expected %0h, got %0h",
                     $realtime, what, radicand, want, got);
    endtask

    // Driver: one beat in flight on the input side; gaps and drain pauses come from the item.
    always @(posedge aclk) begin
        logic                  next_valid;
        logic [RADICAND_W-1:0] next_radicand;
        next_valid    = s_valid;
        next_radicand = s_radicand;
        if (!aresetn) begin
            next_valid  = 1'b0;
            launch_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                root_expect_q.push_back(predict_root(s_radicand));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_q.size() != 0) begin
                if (pending_q[0].drain && root_expect_q.size() != 0) begin
                    launch_wait = 0;
                end else if (launch_wait < pending_q[0].gap) begin
                    launch_wait++;
                end else begin
                    next_valid    = 1'b1;
                    next_radicand = pending_q[0].radicand;
                    pending_q.pop_front();
                    launch_wait = 0;
                end
            end
        end
        s_valid    <= next_valid;
        s_radicand <= next_radicand;
    end

    // Monitor: checks each output beat against the oldest prediction and throttles m_ready.
    always @(posedge aclk) begin
        root_beat_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (root_expect_q.size() == 0) begin
                    flag_mismatch("unexpected beat", '0, 0, m_root);
                end else begin
                    want = root_expect_q.pop_front();
                    if (m_root !== want.root)
                        flag_mismatch("root", want.radicand, want.root, m_root);
                    if (m_invalid !== want.invalid)
                        flag_mismatch("invalid", want.radicand, want.invalid, m_invalid);
                end
                // Every so often the receiver takes a run of beats without stalling.
                hold_left = ((results_seen % 120) < 30) ? 0 : $urandom_range(0, 16);
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0]           wide;
        logic [RADICAND_W-1:0] value;
        int unsigned           gap;
        bit                    drain;

        // Directed part: extremes, sign boundary, zero, exact squares, back to back.
        queue_radicand(32'h0000_0000, 0, 1'b0);
        queue_radicand(32'h0000_0001, 0, 1'b0);
        queue_radicand(32'h0000_0002, 0, 1'b0);
        queue_radicand(32'h0000_0003, 0, 1'b0);
        queue_radicand(32'h0001_0000, 0, 1'b0);
        queue_radicand(32'h0004_0000, 0, 1'b0);
        queue_radicand(32'h0000_4000, 0, 1'b0);
        queue_radicand(32'h0000_FFFF, 3, 1'b0);
        queue_radicand(32'h4000_0000, 0, 1'b0);
        queue_radicand(32'h7FFF_0000, 0, 1'b0);
        queue_radicand(32'h7FFF_FFFE, 0, 1'b0);
        queue_radicand(32'h7FFF_FFFF, 0, 1'b0);
        queue_radicand(32'h8000_0000, 0, 1'b0);
        queue_radicand(32'h8000_0001, 0, 1'b0);
        queue_radicand(32'hFFFF_FFFF, 0, 1'b0);
        queue_radicand(32'hFFFF_0000, 5, 1'b0);
        queue_radicand(32'h5555_5555, 0, 1'b0);
        queue_radicand(32'h2AAA_AAAA, 0, 1'b0);
        queue_radicand(32'h0000_0000, 0, 1'b1);
        queue_radicand(32'h7FFF_FFFF, 0, 1'b0);
        queue_radicand(32'h8000_0000, 0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 5))
                0: value = $urandom;
                1: value = $urandom >> $urandom_range(0, 31);
                2: begin
                    // Land next to a root step so the floor boundary is exercised.
                    wide  = $urandom_range(0, 11863283);
                    wide  = (wide * wide) >> FRAC_BITS;
                    value = wide[31:0] + $urandom_range(0, 2);
                end
                3: begin
                    wide  = $urandom_range(0, 46340);
                    wide  = wide * wide;
                    value = wide[31:0];
                end
                4: value = -$urandom_range(1, 1000);
                default: value = $urandom_range(0, 1000);
            endcase
            gap   = (((i / 40) % 4) == 1) ? 0 : $urandom_range(0, 16);
            drain = ((i % 137) == 68);
            queue_radicand(value, gap, drain);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid || root_expect_q.size() != 0)
            @(posedge aclk);
        repeat (2 * CHAIN_DEPTH) @(posedge aclk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
